// ===== hdl/text_stream_display_filter_macros.svh =====
// Assertion macros shared by the display filter RTL.
`ifndef TEXT_STREAM_DISPLAY_FILTER_MACROS_SVH
`define TEXT_STREAM_DISPLAY_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSDF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsdf assertion failed");

// Next-cycle implication, disabled during reset.
`define TSDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsdf assertion failed");

`endif

// ===== hdl/tsdf_pkg.sv =====
// Shared types and constants of the text stream display filter.
`timescale 1ns / 1ps
package tsdf_pkg;

  localparam int NUMBER_DIGITS_DEF = 6;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int CFG_ADDR_W        = 5;
  localparam int CFG_IDX_W         = CFG_ADDR_W - 2;

  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_LINE_ENDS  = 3'd5;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NL      = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_DOLLAR  = 8'd36;
  localparam logic [7:0] CH_DASH    = 8'd45;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_I       = 8'd73;
  localparam logic [7:0] CH_M       = 8'd77;
  localparam logic [7:0] CH_CARET   = 8'd94;
  localparam logic [7:0] CH_DEL     = 8'd127;
  localparam logic [7:0] CARET_XOR  = 8'h40;

  typedef struct packed {
    logic number_all_lines;
    logic number_nonblank_lines;
    logic squeeze_blank;
    logic show_tabs;
    logic show_nonprinting;
    logic show_line_ends;
  } tsdf_cfg_t;

  // One classified input byte, as handed from front to back.
  typedef struct packed {
    logic       num;
    logic       mdash;
    logic       caret;
    logic       dollar;
    logic [7:0] ch;
  } tsdf_item_t;

  typedef enum logic [2:0] {
    PH_DIGIT,
    PH_TAB,
    PH_M,
    PH_DASH,
    PH_CARET,
    PH_DOLLAR,
    PH_CHAR
  } tsdf_phase_t;

endpackage

// ===== hdl/tsdf_regs.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module tsdf_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tsdf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output tsdf_pkg::tsdf_cfg_t              cfg
);
  import tsdf_pkg::*;

  logic [CFG_IDX_W-1:0] idx;
  logic                 wr;
  logic                 rd_bit;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_NUMBER_ALL:      cfg.number_all_lines      <= pwdata[0];
        REG_NUMBER_NONBLANK: cfg.number_nonblank_lines <= pwdata[0];
        REG_SQUEEZE_BLANK:   cfg.squeeze_blank         <= pwdata[0];
        REG_SHOW_TABS:       cfg.show_tabs             <= pwdata[0];
        REG_SHOW_NONPRINT:   cfg.show_nonprinting      <= pwdata[0];
        REG_SHOW_LINE_ENDS:  cfg.show_line_ends        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NUMBER_ALL:      rd_bit = cfg.number_all_lines;
      REG_NUMBER_NONBLANK: rd_bit = cfg.number_nonblank_lines;
      REG_SQUEEZE_BLANK:   rd_bit = cfg.squeeze_blank;
      REG_SHOW_TABS:       rd_bit = cfg.show_tabs;
      REG_SHOW_NONPRINT:   rd_bit = cfg.show_nonprinting;
      REG_SHOW_LINE_ENDS:  rd_bit = cfg.show_line_ends;
      default:             rd_bit = 1'b0;
    endcase
  end

  assign prdata = {31'd0, rd_bit};

endmodule

// ===== hdl/tsdf_front.sv =====
// Front end: accepts raw bytes, tracks line state and classifies each byte.
`timescale 1ns / 1ps
module tsdf_front #(
  parameter int NUMBER_DIGITS = tsdf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tsdf_pkg::tsdf_cfg_t          cfg,
  input  logic                         push,
  input  logic [7:0]                   in_byte,
  input  logic                         q_full,
  output logic                         q_push,
  output tsdf_pkg::tsdf_item_t         q_item,
  output logic [4*NUMBER_DIGITS-1:0]   q_bcd
);
  import tsdf_pkg::*;

  localparam int BW = 4 * NUMBER_DIGITS;

  logic [7:0]    previous_char;
  logic [BW-1:0] line_number_bcd;
  logic [1:0]    blank_run;

  logic [1:0]    blank_run_next;
  logic [BW-1:0] bcd_next;
  logic          accept;
  logic          drop;
  logic          sq_hit;
  logic [1:0]    run_inc;
  tsdf_item_t    item;

  assign accept = push && !q_full;

  // Squeeze: a newline after a newline bumps the run; at two it is dropped.
  always_comb begin
    sq_hit  = cfg.squeeze_blank && (in_byte == CH_NL) && (previous_char == CH_NL);
    run_inc = (blank_run < 2'd2) ? blank_run + 2'd1 : blank_run;
    blank_run_next = sq_hit ? run_inc : 2'd0;
    drop    = sq_hit && (run_inc == 2'd2);
  end

  // Substitutions and prefixes, in the order the options apply.
  always_comb begin
    item = '0;
    item.ch = in_byte;
    item.num = !drop && (previous_char == CH_NL) &&
               ((cfg.number_all_lines && !cfg.number_nonblank_lines) ||
                (cfg.number_nonblank_lines && in_byte != CH_NL));
    if (cfg.show_tabs && item.ch == CH_TAB) begin
      item.caret = 1'b1;
      item.ch    = CH_I;
    end
    if (cfg.show_nonprinting && item.ch != CH_TAB && item.ch != CH_NL) begin
      if (item.ch[7]) begin
        item.mdash = 1'b1;
        item.ch    = {1'b0, item.ch[6:0]};
      end
      if (item.ch inside {[8'd0:8'd31], CH_DEL}) begin
        item.caret = 1'b1;
        item.ch    = item.ch ^ CARET_XOR;
      end
    end
    item.dollar = cfg.show_line_ends && item.ch == CH_NL;
  end

  // Saturating BCD increment, one digit carry at a time.
  always_comb begin
    logic [3:0] d;
    logic       carry;
    logic       all_nine;
    carry    = 1'b1;
    all_nine = 1'b1;
    bcd_next = line_number_bcd;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      d = line_number_bcd[4*i +: 4];
      if (d != 4'd9) all_nine = 1'b0;
      if (carry) begin
        if (d == 4'd9) begin
          bcd_next[4*i +: 4] = 4'd0;
        end else begin
          bcd_next[4*i +: 4] = d + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (all_nine) bcd_next = line_number_bcd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_char   <= CH_NL;
      line_number_bcd <= BW'(1);
      blank_run       <= 2'd0;
    end else if (accept) begin
      blank_run <= blank_run_next;
      if (!drop) previous_char <= item.ch;
      if (item.num) line_number_bcd <= bcd_next;
    end
  end

  assign q_push = accept && !drop;
  assign q_item = item;
  assign q_bcd  = line_number_bcd;

endmodule

// ===== hdl/tsdf_queue.sv =====
// Small register queue between the front and back ends.
`timescale 1ns / 1ps
module tsdf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tsdf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             q_pop,
  output logic [WIDTH-1:0] rdata,
  output logic             q_valid,
  output logic             q_full
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign q_valid = (count != '0);
  assign q_full  = (count == CW'(DEPTH));
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (q_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (q_push && !q_pop)      count <= count + 1'b1;
      else if (q_pop && !q_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== hdl/tsdf_back.sv =====
// Back end: expands one classified byte into output bytes, one per cycle while popped.
`timescale 1ns / 1ps
module tsdf_back #(
  parameter int NUMBER_DIGITS = tsdf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  tsdf_pkg::tsdf_item_t         q_item,
  input  logic [4*NUMBER_DIGITS-1:0]   q_bcd,
  output logic                         q_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic [7:0]                   out_byte,
  output logic                         last_of_run
);
  import tsdf_pkg::*;

  localparam int BW = 4 * NUMBER_DIGITS;
  localparam int DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

  function automatic tsdf_phase_t after_caret(tsdf_item_t it);
    return it.dollar ? PH_DOLLAR : PH_CHAR;
  endfunction

  function automatic tsdf_phase_t after_dash(tsdf_item_t it);
    return it.caret ? PH_CARET : after_caret(it);
  endfunction

  function automatic tsdf_phase_t after_tab(tsdf_item_t it);
    return it.mdash ? PH_M : after_dash(it);
  endfunction

  tsdf_phase_t   phase, phase_next;
  logic          busy, busy_next;
  logic [DW-1:0] dig, dig_next;
  tsdf_item_t    cur;
  logic [BW-1:0] cur_bcd;
  logic          out_valid;

  logic          take;
  logic          emitting;
  logic          load;
  logic [7:0]    emit_byte;
  logic          emit_last;
  logic [3:0]    digit;
  logic [NUMBER_DIGITS-1:0] upper_nz;

  assign take     = !out_valid || pop;
  assign emitting = busy && take;
  assign load     = q_valid && (!busy || (emitting && phase == PH_CHAR));
  assign q_pop    = load;

  for (genvar g = 0; g < NUMBER_DIGITS; g++) begin : g_nz
    assign upper_nz[g] = |cur_bcd[BW-1:4*g];
  end

  assign digit = cur_bcd[4*dig +: 4];

  // Next state.
  always_comb begin
    phase_next = phase;
    busy_next  = busy;
    dig_next   = dig;
    if (load) begin
      busy_next  = 1'b1;
      dig_next   = DW'(NUMBER_DIGITS - 1);
      phase_next = q_item.num ? PH_DIGIT : after_tab(q_item);
    end else if (emitting) begin
      case (phase)
        PH_DIGIT: begin
          if (dig == '0) phase_next = PH_TAB;
          else           dig_next   = dig - 1'b1;
        end
        PH_TAB:    phase_next = after_tab(cur);
        PH_M:      phase_next = PH_DASH;
        PH_DASH:   phase_next = after_dash(cur);
        PH_CARET:  phase_next = after_caret(cur);
        PH_DOLLAR: phase_next = PH_CHAR;
        PH_CHAR:   busy_next  = 1'b0;
        default:   phase_next = PH_CHAR;
      endcase
    end
  end

  // Byte for the current step; leading zeros print as spaces.
  always_comb begin
    emit_last = 1'b0;
    case (phase)
      PH_DIGIT:  emit_byte = (upper_nz[dig] || dig == '0) ? CH_ZERO + {4'd0, digit}
                                                          : CH_SPACE;
      PH_TAB:    emit_byte = CH_TAB;
      PH_M:      emit_byte = CH_M;
      PH_DASH:   emit_byte = CH_DASH;
      PH_CARET:  emit_byte = CH_CARET;
      PH_DOLLAR: emit_byte = CH_DOLLAR;
      PH_CHAR: begin
        emit_byte = cur.ch;
        emit_last = 1'b1;
      end
      default:   emit_byte = cur.ch;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CHAR;
      busy      <= 1'b0;
      dig       <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      busy  <= busy_next;
      dig   <= dig_next;
      if (emitting)  out_valid <= 1'b1;
      else if (pop)  out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur     <= q_item;
      cur_bcd <= q_bcd;
    end
    if (emitting) begin
      out_byte    <= emit_byte;
      last_of_run <= emit_last;
    end
  end

  assign empty = !out_valid;

endmodule

// ===== hdl/text_stream_display_filter.sv =====
// Path: a pushed byte is queued, loaded into the back-end item register, and its
// first result is registered on out_byte. Throughput: while pop takes each byte,
// the back-end sequencer sends one output byte per cycle, so a byte holds it
// until its results (1 to NUMBER_DIGITS + 5) are sent; a squeezed newline is
// dropped up front, never reaching it. Single-result bytes flow at one per cycle.
// Reset (synchronous rst): options clear, line number goes to 1, queues empty.
`timescale 1ns / 1ps
module text_stream_display_filter #(
  parameter int NUMBER_DIGITS = tsdf_pkg::NUMBER_DIGITS_DEF,
  parameter int QUEUE_DEPTH   = tsdf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tsdf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       in_byte,
  input  logic                             pop,
  output logic                             empty,
  output logic [7:0]                       out_byte,
  output logic                             last_of_run
);
  import tsdf_pkg::*;
  `include "text_stream_display_filter_macros.svh"

  localparam int BW = 4 * NUMBER_DIGITS;
  localparam int QW = $bits(tsdf_item_t) + BW;

  tsdf_cfg_t     cfg;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  logic          q_full;
  tsdf_item_t    f_item;
  logic [BW-1:0] f_bcd;
  tsdf_item_t    b_item;
  logic [BW-1:0] b_bcd;

  tsdf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsdf_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .in_byte (in_byte),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (f_item),
    .q_bcd   (f_bcd)
  );

  tsdf_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .wdata   ({f_item, f_bcd}),
    .q_pop   (q_pop),
    .rdata   ({b_item, b_bcd}),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  tsdf_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (b_item),
    .q_bcd       (b_bcd),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  assign full = q_full;

  `TSDF_ASSERT_IMPLY(a_no_push_when_full, clk, rst, q_full, !q_push)
  `TSDF_ASSERT_IMPLY(a_pop_needs_entry, clk, rst, q_pop, q_valid)
  `TSDF_ASSERT_NEXT(a_run_continues, clk, rst, pop && !empty && !last_of_run, !empty)

endmodule
